// ===== hw/rtl/cbls_pkg.sv =====
// Shared types and constants for the comment and blank-line stripper.
// No dependencies; imported by every module of the block.
package cbls_pkg;

  localparam int CBLS_PENDING_DEPTH = 32;
  localparam int POS_W              = 24;

  // Lexer modes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_SLASH  = 3'd1;
  localparam logic [2:0] MODE_LINE   = 3'd2;
  localparam logic [2:0] MODE_BLOCK  = 3'd3;
  localparam logic [2:0] MODE_BSTAR  = 3'd4;
  localparam logic [2:0] MODE_HALTED = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FATAL    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Characters
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // One queued result, not from the whitespace buffer
  typedef struct packed {
    logic       vld;
    logic       bv;
    logic [1:0] st;
    logic [6:0] ch;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic plan_any;   // incoming item yields at least one result
    logic more;       // more than one result still queued
    logic out_free;   // output register can take a result this cycle
  } dp_stat_t;

endpackage

// ===== hw/rtl/cbls_ctrl.sv =====
// Controller for the stripper: accept/emit sequencing.
// Depends on cbls_pkg.
module cbls_ctrl
  import cbls_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic state_r;
  logic state_nxt;

  assign in_stall   = (state_r != S_IDLE);
  assign cmd.accept = in_valid && (state_r == S_IDLE);
  assign cmd.emit   = (state_r == S_EMIT) && stat.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept && stat.plan_any) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (cmd.emit && !stat.more) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/cbls_dp.sv =====
// Datapath for the stripper: lexer state, whitespace buffer, result queue,
// output register. Depends on cbls_pkg.
module cbls_dp
  import cbls_pkg::*;
#(
  parameter int PENDING_DEPTH = CBLS_PENDING_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_cmd_t        cmd,
  output dp_stat_t         stat,
  input  logic [7:0]       in_src_byte,
  input  logic             in_end_of_source,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [6:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_last,
  output logic [1:0]       out_status,
  output logic [POS_W-1:0] out_error_line,
  output logic [POS_W-1:0] out_error_column,
  output logic             out_done_res
);

  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Lexer state
  logic [2:0]               mode_r, mode_nxt;
  logic                     lcs_r, lcs_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [POS_W-1:0]         line_r, line_nxt;
  logic [POS_W-1:0]         col_r, col_nxt;
  logic [PENDING_DEPTH-1:0] kinds_r, kinds_nxt;

  // Result queue of the item in flight
  logic [CNT_W-1:0]         fl_r, fl_nxt;
  res_t                     t0_r, t0_nxt, t1_r, t1_nxt;
  logic                     done_r, done_nxt;
  logic [POS_W-1:0]         eline_r, eline_nxt;
  logic [POS_W-1:0]         ecol_r, ecol_nxt;

  // Output register
  logic                     ov_r, ov_nxt;
  logic [6:0]               ob_r, ob_nxt;
  logic                     obv_r, obv_nxt;
  logic                     olast_r, olast_nxt;
  logic [1:0]               ost_r, ost_nxt;
  logic [POS_W-1:0]         oline_r, oline_nxt;
  logic [POS_W-1:0]         ocol_r, ocol_nxt;
  logic                     odone_r, odone_nxt;

  // Per-item decode
  logic [2:0]       m;
  logic             lcs;
  logic [CNT_W-1:0] cnt;
  logic             flush, wr, take;
  res_t             t0, t1, r;
  res_t             sel;
  logic [7:0]       c;

  assign c = in_src_byte;

  // Decode of the incoming item against the current lexer state
  always_comb begin
    m     = mode_r;
    lcs   = lcs_r;
    cnt   = cnt_r;
    flush = 1'b0;
    wr    = 1'b0;
    take  = 1'b0;
    t0    = '0;
    t1    = '0;
    r     = '0;
    if (mode_r == MODE_HALTED) begin
      t0 = '{vld: 1'b1, bv: 1'b0, st: ST_FATAL, ch: 7'd0};
    end else if (in_end_of_source) begin
      flush = 1'b1;
      if (mode_r == MODE_SLASH) begin
        t0 = '{vld: 1'b1, bv: 1'b1, st: ST_OK, ch: CH_SLASH[6:0]};
      end else if (cnt_r == '0) begin
        t0 = '{vld: 1'b1, bv: 1'b0, st: ST_OK, ch: 7'd0};
      end
      m   = MODE_NORMAL;
      lcs = 1'b0;
      cnt = '0;
    end else begin
      case (mode_r)
        MODE_LINE: begin
          if (c == CH_NL) begin
            m = MODE_NORMAL;
            if (lcs_r) t0 = '{vld: 1'b1, bv: 1'b1, st: ST_OK, ch: CH_NL[6:0]};
            cnt = '0;
            lcs = 1'b0;
          end
        end
        MODE_BLOCK: begin
          if (c == CH_STAR) m = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          if (c == CH_SLASH) m = MODE_NORMAL;
          else if (c != CH_STAR) m = MODE_BLOCK;
        end
        default: begin
          take = 1'b1;
          if (mode_r == MODE_SLASH) begin
            if (c == CH_SLASH) begin
              m    = MODE_LINE;
              take = 1'b0;
            end else if (c == CH_STAR) begin
              m    = MODE_BLOCK;
              take = 1'b0;
            end else begin
              // held slash was content after all
              m     = MODE_NORMAL;
              flush = 1'b1;
              cnt   = '0;
              lcs   = 1'b1;
              t0    = '{vld: 1'b1, bv: 1'b1, st: ST_OK, ch: CH_SLASH[6:0]};
            end
          end
          if (take) begin
            if (c[7]) begin
              cnt = '0;
              m   = MODE_HALTED;
              r   = '{vld: 1'b1, bv: 1'b0, st: ST_FATAL, ch: 7'd0};
            end else if (c == CH_SLASH) begin
              m = MODE_SLASH;
            end else if (c == CH_NL) begin
              if (lcs) r = '{vld: 1'b1, bv: 1'b1, st: ST_OK, ch: CH_NL[6:0]};
              cnt = '0;
              lcs = 1'b0;
            end else if (c inside {CH_SPACE, CH_TAB}) begin
              if (lcs) begin
                r = '{vld: 1'b1, bv: 1'b1, st: ST_OK, ch: c[6:0]};
              end else if (cnt_r < CNT_W'(PENDING_DEPTH)) begin
                wr  = 1'b1;
                cnt = cnt_r + CNT_W'(1);
              end else begin
                r = '{vld: 1'b1, bv: 1'b0, st: ST_OVERFLOW, ch: 7'd0};
              end
            end else begin
              flush = 1'b1;
              cnt   = '0;
              lcs   = 1'b1;
              r     = '{vld: 1'b1, bv: 1'b1, st: ST_OK, ch: c[6:0]};
            end
            if (t0.vld) t1 = r;
            else t0 = r;
          end
        end
      endcase
    end
  end

  // Next emitted result: buffered whitespace first, then t0, then t1
  always_comb begin
    if (fl_r != '0) begin
      sel = '{vld: 1'b1, bv: 1'b1, st: ST_OK,
              ch: (kinds_r[0] ? CH_TAB[6:0] : CH_SPACE[6:0])};
    end else if (t0_r.vld) begin
      sel = t0_r;
    end else begin
      sel = t1_r;
    end
  end

  assign stat.plan_any = (flush && (cnt_r != '0)) || t0.vld || t1.vld;
  assign stat.more     = (fl_r > CNT_W'(1)) || ((fl_r != '0) && t0_r.vld)
                         || (t0_r.vld && t1_r.vld);
  assign stat.out_free = !ov_r || !out_stall;

  always_comb begin
    mode_nxt  = mode_r;
    lcs_nxt   = lcs_r;
    cnt_nxt   = cnt_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    kinds_nxt = kinds_r;
    fl_nxt    = fl_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    done_nxt  = done_r;
    eline_nxt = eline_r;
    ecol_nxt  = ecol_r;
    ov_nxt    = ov_r && out_stall;
    ob_nxt    = ob_r;
    obv_nxt   = obv_r;
    olast_nxt = olast_r;
    ost_nxt   = ost_r;
    oline_nxt = oline_r;
    ocol_nxt  = ocol_r;
    odone_nxt = odone_r;

    if (cmd.accept) begin
      mode_nxt  = m;
      lcs_nxt   = lcs;
      cnt_nxt   = cnt;
      fl_nxt    = flush ? cnt_r : '0;
      t0_nxt    = t0;
      t1_nxt    = t1;
      done_nxt  = in_end_of_source;
      eline_nxt = line_r;
      ecol_nxt  = col_r;
      for (int i = 0; i < PENDING_DEPTH; i++) begin
        if (wr && (cnt_r == CNT_W'(i))) kinds_nxt[i] = (c == CH_TAB);
      end
      if (mode_r != MODE_HALTED) begin
        if (in_end_of_source) begin
          line_nxt = POS_W'(1);
          col_nxt  = POS_W'(1);
        end else if (m != MODE_HALTED) begin
          if (c == CH_NL) begin
            if (line_r != POS_MAX) line_nxt = line_r + POS_W'(1);
            col_nxt = POS_W'(1);
          end else if (col_r != POS_MAX) begin
            col_nxt = col_r + POS_W'(1);
          end
        end
      end
    end

    if (cmd.emit) begin
      ov_nxt    = 1'b1;
      ob_nxt    = sel.ch;
      obv_nxt   = sel.bv;
      ost_nxt   = sel.st;
      olast_nxt = !stat.more;
      odone_nxt = !stat.more && done_r;
      oline_nxt = (sel.st != ST_OK) ? eline_r : '0;
      ocol_nxt  = (sel.st != ST_OK) ? ecol_r : '0;
      if (fl_r != '0) begin
        fl_nxt    = fl_r - CNT_W'(1);
        kinds_nxt = kinds_r >> 1;
      end else begin
        t0_nxt = t1_r;
        t1_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      lcs_r  <= 1'b0;
      cnt_r  <= '0;
      line_r <= POS_W'(1);
      col_r  <= POS_W'(1);
      fl_r   <= '0;
      t0_r   <= '0;
      t1_r   <= '0;
      ov_r   <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      lcs_r  <= lcs_nxt;
      cnt_r  <= cnt_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      fl_r   <= fl_nxt;
      t0_r   <= t0_nxt;
      t1_r   <= t1_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kinds_r <= kinds_nxt;
    done_r  <= done_nxt;
    eline_r <= eline_nxt;
    ecol_r  <= ecol_nxt;
    ob_r    <= ob_nxt;
    obv_r   <= obv_nxt;
    olast_r <= olast_nxt;
    ost_r   <= ost_nxt;
    oline_r <= oline_nxt;
    ocol_r  <= ocol_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid        = ov_r;
  assign out_byte         = ob_r;
  assign out_byte_valid   = obv_r;
  assign out_last         = olast_r;
  assign out_status       = ost_r;
  assign out_error_line   = oline_r;
  assign out_error_column = ocol_r;
  assign out_done_res     = odone_r;

endmodule

// ===== hw/rtl/comment_and_blank_line_stripper.sv =====
// Top level of the comment and blank-line stripper.
// Depends on cbls_pkg, cbls_ctrl and cbls_dp.
//
// Streams C-like source one byte per input transfer and returns the cleaned
// text, one character per output transfer. Line comments are cut before their
// newline, block comments vanish with any newlines inside them, and lines that
// hold only spaces and tabs are dropped. Leading whitespace sits in a
// PENDING_DEPTH-entry buffer until the line shows content; a leading blank
// that finds it full is dropped and reported with status overflow. A byte
// above 127 outside comments yields one fatal result with its 1-based line
// and column, after which every transfer answers fatal until reset. An input
// with in_end_of_source set flushes held whitespace and a held slash, marks
// its final result with out_done_res, and returns the block to its reset
// state. out_last flags the final result of each input transfer; a transfer
// that yields nothing (comment bytes, buffered blanks) gives no result.
// An input that yields no result leaves the block ready for the next one;
// one that yields N results is accepted, then its results go in turn into
// the single output register. N is at most PENDING_DEPTH+2, bounded by the
// buffered-whitespace flush, which leaves the buffer one entry per cycle
// through a shift line unless out_stall holds it. The next transfer is taken
// as soon as the last result has been loaded, even if it still waits.
module comment_and_blank_line_stripper
  import cbls_pkg::*;
#(
  parameter int PENDING_DEPTH = CBLS_PENDING_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_src_byte,
  input  logic             in_end_of_source,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [6:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_last,
  output logic [1:0]       out_status,
  output logic [POS_W-1:0] out_error_line,
  output logic [POS_W-1:0] out_error_column,
  output logic             out_done_res
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencing: accept one transfer, then drain its results
  cbls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // lexer, whitespace buffer and output register
  cbls_dp #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_src_byte      (in_src_byte),
    .in_end_of_source (in_end_of_source),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last         (out_last),
    .out_status       (out_status),
    .out_error_line   (out_error_line),
    .out_error_column (out_error_column),
    .out_done_res     (out_done_res)
  );

endmodule

// ===== bench/tb_comment_and_blank_line_stripper.sv =====
// Self-checking testbench for comment_and_blank_line_stripper.
// Depends on cbls_pkg and the RTL of the block; a queue-fed driver, a monitor
// and a transfer-level predictor of the stripper check every output transfer.
module tb_comment_and_blank_line_stripper;
  timeunit 1ns;
  timeprecision 1ps;

  import cbls_pkg::*;

  localparam int DEPTH      = CBLS_PENDING_DEPTH;
  localparam int IDLE_LIMIT = 4000;   // cycles with no transfer on either side
  localparam int ITEM_GOAL  = 470;
  localparam logic [23:0] POS_TOP = 24'hFFFFFF;

  // One expected (or observed) output transfer
  typedef struct packed {
    logic [6:0]  ch;
    logic        bv;
    logic        last;
    logic [1:0]  st;
    logic [23:0] ln;
    logic [23:0] col;
    logic        done;
  } clean_res_t;

  // One source byte waiting to be sent, with its lead-in gap
  typedef struct {
    logic [7:0] b;
    logic       eos;
    int         gap;
    bit         drain;   // hold off until every expected result is back
  } src_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_src_byte = '0;
  logic              in_end_of_source = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [6:0]        out_byte;
  logic              out_byte_valid;
  logic              out_last;
  logic [1:0]        out_status;
  logic [POS_W-1:0]  out_error_line;
  logic [POS_W-1:0]  out_error_column;
  logic              out_done_res;

  comment_and_blank_line_stripper uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_src_byte      (in_src_byte),
    .in_end_of_source (in_end_of_source),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last         (out_last),
    .out_status       (out_status),
    .out_error_line   (out_error_line),
    .out_error_column (out_error_column),
    .out_done_res     (out_done_res)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  src_item_t  src_q[$];
  clean_res_t clean_q[$];    // expected output transfers, oldest first
  clean_res_t step_q[$];     // results of the byte being predicted

  int err_cnt   = 0;
  int idle_cyc  = 0;
  int idle_left = 0;
  int hold_left = 0;
  bit tx_calm   = 1'b0;
  bit rx_calm   = 1'b0;

  // ---------------------------------------------------------------------
  // Predictor state
  // ---------------------------------------------------------------------
  logic [2:0]  lx_mode;
  bit          content_seen;
  bit          blank_kind[DEPTH];   // 1 = tab, 0 = space
  int          blank_cnt;
  logic [23:0] cur_line;
  logic [23:0] cur_col;

  function automatic void clear_state();
    lx_mode      = MODE_NORMAL;
    content_seen = 1'b0;
    blank_cnt    = 0;
    cur_line     = 24'd1;
    cur_col      = 24'd1;
  endfunction

  function automatic void push_res(logic [6:0] ch, logic bv, logic [1:0] st,
                                   logic [23:0] ln, logic [23:0] col);
    clean_res_t r;
    r     = '0;
    r.ch  = ch;
    r.bv  = bv;
    r.st  = st;
    r.ln  = ln;
    r.col = col;
    step_q.push_back(r);
  endfunction

  function automatic void emit_char(logic [7:0] ch);
    push_res(ch[6:0], 1'b1, ST_OK, '0, '0);
  endfunction

  // Write out buffered leading blanks
  function automatic void flush_blanks();
    for (int i = 0; i < blank_cnt && i < DEPTH; i++)
      emit_char(blank_kind[i] ? CH_TAB : CH_SPACE);
    blank_cnt = 0;
  endfunction

  function automatic void content_char(logic [7:0] ch);
    flush_blanks();
    content_seen = 1'b1;
    emit_char(ch);
  endfunction

  // ASCII byte seen in normal mode
  function automatic void plain_byte(logic [7:0] c, logic [23:0] ln, logic [23:0] col);
    if (c == CH_SLASH) begin
      lx_mode = MODE_SLASH;
    end else if (c == CH_NL) begin
      if (content_seen) emit_char(CH_NL);
      blank_cnt    = 0;
      content_seen = 1'b0;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      if (content_seen) begin
        emit_char(c);
      end else if (blank_cnt < DEPTH) begin
        blank_kind[blank_cnt] = (c == CH_TAB);
        blank_cnt++;
      end else begin
        push_res('0, 1'b0, ST_OVERFLOW, ln, col);
      end
    end else begin
      content_char(c);
    end
  endfunction

  // Works out the output transfers caused by one accepted source byte
  function automatic void strip_predict(logic [7:0] c, logic eos);
    logic [23:0] ln;
    logic [23:0] col;
    ln  = cur_line;
    col = cur_col;
    step_q.delete();
    if (lx_mode == MODE_HALTED) begin
      push_res('0, 1'b0, ST_FATAL, ln, col);
      step_q[0].done = eos;
    end else if (eos) begin
      flush_blanks();
      if (lx_mode == MODE_SLASH) emit_char(CH_SLASH);
      if (step_q.size() == 0) push_res('0, 1'b0, ST_OK, '0, '0);
      step_q[step_q.size()-1].done = 1'b1;
      clear_state();
    end else begin
      case (lx_mode)
        MODE_LINE: begin
          if (c == CH_NL) begin
            lx_mode = MODE_NORMAL;
            plain_byte(c, ln, col);
          end
        end
        MODE_BLOCK: begin
          if (c == CH_STAR) lx_mode = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          if (c == CH_SLASH) lx_mode = MODE_NORMAL;
          else if (c != CH_STAR) lx_mode = MODE_BLOCK;
        end
        default: begin
          if (lx_mode == MODE_SLASH && c == CH_SLASH) begin
            lx_mode = MODE_LINE;
          end else if (lx_mode == MODE_SLASH && c == CH_STAR) begin
            lx_mode = MODE_BLOCK;
          end else begin
            // held slash turned out to be content
            if (lx_mode == MODE_SLASH) begin
              lx_mode = MODE_NORMAL;
              content_char(CH_SLASH);
            end
            if (c[7]) begin
              blank_cnt = 0;
              lx_mode   = MODE_HALTED;
              push_res('0, 1'b0, ST_FATAL, ln, col);
            end else begin
              plain_byte(c, ln, col);
            end
          end
        end
      endcase
      // position freezes once halted
      if (lx_mode != MODE_HALTED) begin
        if (c == CH_NL) begin
          if (cur_line < POS_TOP) cur_line++;
          cur_col = 24'd1;
        end else if (cur_col < POS_TOP) begin
          cur_col++;
        end
      end
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) clean_q.push_back(step_q[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void add_item(logic [7:0] b, logic eos);
    src_item_t it;
    if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
    it.b     = b;
    it.eos   = eos;
    it.gap   = pick_gap(tx_calm);
    it.drain = ($urandom_range(0, 59) == 0);
    src_q.push_back(it);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
  endfunction

  function automatic void add_eos();
    add_item(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  // content byte: never a slash, never a blank or newline
  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'h7F;
    if (r == 2) return CH_STAR;
    b = 8'($urandom_range(8'h21, 8'h7E));
    if (b == CH_SLASH) b = 8'h61;
    return b;
  endfunction

  // byte inside a comment: anything but a slash or newline as asked
  function automatic logic [7:0] comment_byte(bit no_nl);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_SLASH || (no_nl && b == CH_NL)) b = 8'hA5;
    return b;
  endfunction

  function automatic void add_blanks(int n);
    for (int i = 0; i < n; i++) add_item($urandom_range(0, 1) ? CH_TAB : CH_SPACE, 1'b0);
  endfunction

  // One well-formed chunk of source text, or a little noise
  function automatic void add_chunk();
    int r;
    int n;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) add_item(word_byte(), 1'b0);
    end else if (r < 45) begin
      add_blanks($urandom_range(1, 3));
    end else if (r < 60) begin
      add_item(CH_NL, 1'b0);
    end else if (r < 67) begin
      add_text("//");
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) add_item(comment_byte(1'b1), 1'b0);
      add_item(CH_NL, 1'b0);
    end else if (r < 75) begin
      add_text("/*");
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) add_item(comment_byte(1'b0), 1'b0);
      // an open comment cut off by the end of source
      if ($urandom_range(0, 5) == 0) add_eos();
      else add_text("*/");
    end else if (r < 81) begin
      add_item(CH_SLASH, 1'b0);
      case ($urandom_range(0, 4))
        0: add_item(CH_SPACE, 1'b0);
        1: add_item(CH_NL, 1'b0);
        2: add_eos();
        default: add_item(word_byte(), 1'b0);
      endcase
    end else if (r < 85) begin
      // long leading run, past the buffer depth now and then
      add_item(CH_NL, 1'b0);
      add_blanks($urandom_range(DEPTH - 2, DEPTH + 4));
      case ($urandom_range(0, 3))
        0: add_item(CH_NL, 1'b0);
        1: add_eos();
        2: add_text("/x");
        default: add_item(word_byte(), 1'b0);
      endcase
    end else if (r < 90) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(0, 127));
        if (b == CH_SLASH || b == CH_STAR) b = 8'h3B;
        add_item(b, 1'b0);
      end
    end else if (r < 94) begin
      add_eos();
    end else begin
      add_item(CH_NL, 1'b0);
      add_blanks($urandom_range(1, 4));
      add_item(CH_NL, 1'b0);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents the head of src_q, pops it on transfer
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    bit fire;
    fire = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        strip_predict(in_src_byte, in_end_of_source);
        void'(src_q.pop_front());
        if (src_q.size() > 0) idle_left = src_q[0].gap;
      end
      if (fire || !in_valid) begin
        if (src_q.size() > 0 && idle_left == 0 &&
            !(src_q[0].drain && clean_q.size() > 0)) begin
          in_valid         <= 1'b1;
          in_src_byte      <= src_q[0].b;
          in_end_of_source <= src_q[0].eos;
        end else begin
          in_valid <= 1'b0;
          if (idle_left > 0) idle_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each output transfer, drives random back-pressure
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    clean_res_t got;
    clean_res_t want;
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.ch   = out_byte;
        got.bv   = out_byte_valid;
        got.last = out_last;
        got.st   = out_status;
        got.ln   = out_error_line;
        got.col  = out_error_column;
        got.done = out_done_res;
        if (clean_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("ERROR %0t: unexpected transfer", $realtime);
            $display("  got ch=%h bv=%b last=%b st=%0d ln=%0d col=%0d done=%b",
                     got.ch, got.bv, got.last, got.st, got.ln, got.col, got.done);
          end
        end else begin
          want = clean_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("ERROR %0t: mismatch", $realtime);
              $display("  exp ch=%h bv=%b last=%b st=%0d ln=%0d col=%0d done=%b",
                       want.ch, want.bv, want.last, want.st, want.ln, want.col, want.done);
              $display("  got ch=%h bv=%b last=%b st=%0d ln=%0d col=%0d done=%b",
                       got.ch, got.bv, got.last, got.st, got.ln, got.col, got.done);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        r = $urandom_range(0, 99);
        if (rx_calm || r < 65) hold_left = 0;
        else if (r < 95) hold_left = $urandom_range(1, 3);
        else hold_left = $urandom_range(10, 50);
      end
    end
  end

  // idle cycle count for the watchdog
  always @(posedge clk) begin
    if (!rst_n) idle_cyc <= 0;
    else if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
  end

  initial begin
    while (idle_cyc < IDLE_LIMIT) @(posedge clk);
    $display("tb_comment_and_blank_line_stripper: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int body_n;
    clear_state();

    // Directed: zero byte, lone slash, blanks after content, blank-only
    // line, line comment, block comment holding a high byte and a newline,
    // leading tab, DEL, slash and blank held at end of source.
    add_item(8'h00, 1'b0);
    add_text("/x \t\n");
    add_text(" \t\n");
    add_text("//z\n");
    add_text("/*");
    add_item(8'hFF, 1'b0);
    add_text("\n**/");
    add_text("\tq");
    add_item(8'h7F, 1'b0);
    add_item(CH_SLASH, 1'b0);
    add_eos();
    add_item(CH_SPACE, 1'b0);
    add_eos();

    // Random body; the worst case (full buffer, held slash, content) first,
    // behind a full drain of the pipe.
    body_n = src_q.size();
    add_item(CH_NL, 1'b0);
    src_q[body_n].drain = 1'b1;
    add_blanks(DEPTH);
    add_text("/x");
    while (src_q.size() < ITEM_GOAL - 8) add_chunk();

    // Non-ASCII outside a comment halts the block for good, so it comes last:
    // held slash written before the fatal result, then halted answers.
    add_text("k/");
    src_q[src_q.size()-2].drain = 1'b1;
    add_item(8'hC8, 1'b0);
    add_item(8'h61, 1'b0);
    add_eos();
    add_item(8'h80, 1'b0);
    add_eos();
    idle_left = src_q[0].gap;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (src_q.size() > 0 || in_valid) @(posedge clk);
    while (clean_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (err_cnt == 0 && clean_q.size() == 0) begin
      $display("tb_comment_and_blank_line_stripper: done, clean");
    end else begin
      $display("tb_comment_and_blank_line_stripper: done, errors");
    end
    $finish;
  end

endmodule
